>>> src/sgl_pkg.sv
// ---------------------------------------------------------------------------
// sgl_pkg
// Shared types and constants for the supercover grid line marker.
// ---------------------------------------------------------------------------
package sgl_pkg;

  localparam int MAX_SIDE  = 32;
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int DIM_W     = SIDE_W + 1;
  localparam int CELL_W    = 2 * SIDE_W;
  localparam int CNT_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int MAP_ROWS  = MAX_SIDE;
  localparam int ROW_AW    = SIDE_W;
  localparam int ROW_BITS  = MAX_SIDE;
  localparam int PROD_W    = SIDE_W + DIM_W;

  localparam logic REQ_DRAW  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] GRID_RESET = DIM_W'(MAX_SIDE);

  typedef struct packed {
    logic              req_type;
    logic [SIDE_W-1:0] from_x;
    logic [SIDE_W-1:0] from_y;
    logic [SIDE_W-1:0] to_x;
    logic [SIDE_W-1:0] to_y;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]   cell_index;
    logic                already_marked;
    logic [CNT_W-1:0]    touched_count;
    logic [CNT_W-1:0]    fresh_count;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic latch_req;
    logic start_walk;
    logic clear_en;
    logic read_en;
    logic visit;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic req_ok;
    logic walk_done;
    logic out_free;
    logic clear_last;
  } dp_status_t;

endpackage

>>> src/sgl_ram.sv
// ---------------------------------------------------------------------------
// sgl_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module sgl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/sgl_ctrl.sv
// ---------------------------------------------------------------------------
// sgl_ctrl
// Request sequencer: bitmap wipe, decode, row sweep, cell walk and report.
// ---------------------------------------------------------------------------
module sgl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sgl_pkg::dp_status_t sts,
  output sgl_pkg::ctrl_cmd_t  cmd
);
  import sgl_pkg::*;

  localparam logic [2:0] ST_WIPE   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_VISIT  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_WIPE: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_clear) begin
          state_nxt = ST_CLEAR;
        end else if (sts.req_ok) begin
          cmd.start_walk = 1'b1;
          state_nxt      = ST_READ;
        end else begin
          state_nxt = ST_REPORT;
        end
      end
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.read_en = 1'b1;
        state_nxt   = ST_VISIT;
      end
      ST_VISIT: begin
        if (sts.out_free) begin
          cmd.visit = 1'b1;
          state_nxt = sts.walk_done ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WIPE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/sgl_datapath.sv
// ---------------------------------------------------------------------------
// sgl_datapath
// Grid registers, walk state, visited bitmap and result register.
// ---------------------------------------------------------------------------
module sgl_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sgl_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sgl_pkg::out_item_t       out_data,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [sgl_pkg::DIM_W-1:0] cfg_wdata,
  input  sgl_pkg::ctrl_cmd_t       cmd,
  output sgl_pkg::dp_status_t      sts
);
  import sgl_pkg::*;

  logic [DIM_W-1:0]  grid_w_r, grid_h_r;
  in_item_t          req_r;
  logic [SIDE_W-1:0] dx_r, dy_r;
  logic [SIDE_W-1:0] walk_x_r, walk_y_r;
  logic [SIDE_W-1:0] cc_r, cr_r;
  logic [CNT_W-1:0]  tcnt_r, acnt_r;
  logic              step_x_r, step_y_r;
  logic [ROW_AW-1:0] clr_cnt_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              dims_ok;
  logic [PROD_W-1:0] prod, cell_sum, xb, yb;
  logic [CELL_W-1:0] cell_idx;
  logic [ROW_AW-1:0] cell_row;
  logic [SIDE_W-1:0] cell_bit;
  logic [ROW_BITS-1:0] rd_row, wr_row;
  logic              marked;
  logic [CNT_W-1:0]  tcnt_nxt, acnt_nxt;
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic              out_load;
  out_item_t         out_item_nxt;

  assign dims_ok = (grid_w_r != '0) && (grid_w_r <= GRID_RESET) &&
                   (grid_h_r != '0) && (grid_h_r <= GRID_RESET);

  assign sts.is_clear   = (req_r.req_type == REQ_CLEAR);
  assign sts.req_ok     = dims_ok &&
                          ({1'b0, req_r.from_x} < grid_w_r) &&
                          ({1'b0, req_r.to_x}   < grid_w_r) &&
                          ({1'b0, req_r.from_y} < grid_h_r) &&
                          ({1'b0, req_r.to_y}   < grid_h_r);
  assign sts.walk_done  = (cc_r == dx_r) && (cr_r == dy_r);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.clear_last = &clr_cnt_r;

  assign prod     = PROD_W'(walk_y_r) * PROD_W'(grid_w_r);
  assign cell_sum = prod + PROD_W'(walk_x_r);
  assign cell_idx = cell_sum[CELL_W-1:0];
  assign cell_row = cell_idx[CELL_W-1 -: ROW_AW];
  assign cell_bit = cell_idx[SIDE_W-1:0];

  assign xb = PROD_W'({cc_r, 1'b1}) * PROD_W'(dy_r);
  assign yb = PROD_W'({cr_r, 1'b1}) * PROD_W'(dx_r);

  assign marked   = rd_row[cell_bit];
  assign wr_row   = rd_row | (ROW_BITS'(1) << cell_bit);
  assign tcnt_nxt = tcnt_r + CNT_W'(1);
  assign acnt_nxt = acnt_r + CNT_W'(!marked);

  assign ram_we    = cmd.clear_en || (cmd.visit && !marked);
  assign ram_waddr = cmd.clear_en ? clr_cnt_r : cell_row;

  sgl_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAP_ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (cmd.clear_en ? '0 : wr_row),
    .rd_en   (cmd.read_en),
    .rd_addr (cell_row),
    .rd_data (rd_row)
  );

  always_comb begin
    out_load     = cmd.visit || cmd.report;
    out_item_nxt = '0;
    if (cmd.visit) begin
      out_item_nxt.cell_index     = cell_idx;
      out_item_nxt.already_marked = marked;
      out_item_nxt.touched_count  = tcnt_nxt;
      out_item_nxt.fresh_count    = acnt_nxt;
      out_item_nxt.status         = STATUS_OK;
      out_item_nxt.last           = sts.walk_done;
    end else begin
      out_item_nxt.status = sts.is_clear ? STATUS_CLEARED : STATUS_INVALID;
      out_item_nxt.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r    <= GRID_RESET;
      grid_h_r    <= GRID_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == CFG_GRID_WIDTH) begin
        grid_w_r <= cfg_wdata;
      end
      if (cfg_wr_en && cfg_index == CFG_GRID_HEIGHT) begin
        grid_h_r <= cfg_wdata;
      end
      if (cmd.clear_en) begin
        clr_cnt_r <= clr_cnt_r + ROW_AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
    if (cmd.start_walk) begin
      walk_x_r <= req_r.from_x;
      walk_y_r <= req_r.from_y;
      dx_r     <= (req_r.from_x < req_r.to_x) ? req_r.to_x - req_r.from_x
                                              : req_r.from_x - req_r.to_x;
      dy_r     <= (req_r.from_y < req_r.to_y) ? req_r.to_y - req_r.from_y
                                              : req_r.from_y - req_r.to_y;
      cc_r     <= '0;
      cr_r     <= '0;
      tcnt_r   <= '0;
      acnt_r   <= '0;
    end
    if (cmd.read_en) begin
      step_x_r <= (xb <= yb);
      step_y_r <= (xb >= yb);
    end
    if (cmd.visit) begin
      tcnt_r <= tcnt_nxt;
      acnt_r <= acnt_nxt;
      if (step_x_r) begin
        if (req_r.from_x < req_r.to_x) begin
          walk_x_r <= walk_x_r + SIDE_W'(1);
        end else if (req_r.from_x > req_r.to_x) begin
          walk_x_r <= walk_x_r - SIDE_W'(1);
        end
        cc_r <= cc_r + SIDE_W'(1);
      end
      if (step_y_r) begin
        if (req_r.from_y < req_r.to_y) begin
          walk_y_r <= walk_y_r + SIDE_W'(1);
        end else if (req_r.from_y > req_r.to_y) begin
          walk_y_r <= walk_y_r - SIDE_W'(1);
        end
        cr_r <= cr_r + SIDE_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> src/supercover_grid_line_marker.sv
// ---------------------------------------------------------------------------
// supercover_grid_line_marker
// Walks the supercover cells of a grid line, marking a visited bitmap.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    sgl_pkg::in_item_t
//   out_     output     out_valid/out_ready  sgl_pkg::out_item_t
//   cfg_     input      cfg_wr_en            cfg_index, cfg_wdata
//
// During a draw each cell reads and tests one bitmap row, and writes it back
// if the cell is fresh, through the row RAM with its registered read.
// A clear sweeps all 32 bitmap rows to zero between decode and report.
// After reset a sweep of all 32 bitmap rows zeroes the bitmap with in_ready low.
// A stalled result holds the walk until out_ready frees the output register.
// ---------------------------------------------------------------------------
module supercover_grid_line_marker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sgl_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sgl_pkg::out_item_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [sgl_pkg::DIM_W-1:0] cfg_wdata
);
  import sgl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  sgl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgl_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> src/sgl_checker.sv
// ---------------------------------------------------------------------------
// sgl_checker
// Port-level assertions for the supercover grid line marker.
// ---------------------------------------------------------------------------
module sgl_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input sgl_pkg::out_item_t        out_data
);
  import sgl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transfer taken while a request is in work");

  a_special_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |-> out_data.last &&
      out_data.cell_index == '0 && out_data.touched_count == '0 &&
      out_data.fresh_count == '0 && !out_data.already_marked)
    else $error("bad special result");

  a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_OK && out_data.touched_count == CNT_W'(1)
      |-> out_data.fresh_count == CNT_W'(!out_data.already_marked))
    else $error("first cell counts inconsistent");

endmodule

bind supercover_grid_line_marker sgl_checker u_sgl_checker (.*);
